### hdl/c3sf_pkg.sv
// c3sf_pkg: shared types, constants and helpers for the 3x3 stream filter.
// No dependencies; used by the channel interfaces and the top level.
package c3sf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COEF_BITS  = 16;

  localparam int PIX_W   = 8;
  localparam int POS_W   = 10;                        // out_row / out_col width
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = 11;
  localparam int KROW_W  = 48;
  localparam int SLOT_W  = 16;
  localparam int SHIFT_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;

  // product of an unsigned pixel (made signed) and a coefficient, then sums
  localparam int PROD_W = COEF_BITS + PIX_W + 1;
  localparam int RSUM_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_BOTTOM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SHIFT = 3'd5;

  localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 11'd512;
  localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 11'd512;
  localparam logic [KROW_W-1:0]  KROW_OUTER_RESET = 48'h0001_0002_0001;
  localparam logic [KROW_W-1:0]  KROW_MID_RESET   = 48'h0002_0004_0002;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 4'd4;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1) + 1;  // also holds count + in flight

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             has_int;
    logic             has_bord;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [PIX_W-1:0] filt;
  } entry_t;

  // coefficient idx of a kernel row register: low COEF_BITS of its slot, signed
  function automatic logic signed [COEF_BITS-1:0] kcoef(input logic [KROW_W-1:0] krow,
                                                      input int idx);
    kcoef = $signed(krow[SLOT_W*idx +: COEF_BITS]);
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    if (v < SIZE_W'(3)) clamp_size = SIZE_W'(3);
    else if (v > hi)    clamp_size = hi;
    else                clamp_size = v;
  endfunction

endpackage

### hdl/c3sf_stream_ifs.sv
// c3sf stream channels: source pixels in, filtered results out.
// Depends on c3sf_pkg for field widths.
interface c3sf_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [c3sf_pkg::PIX_W-1:0]   pixel_in;
  logic                         frame_start;
  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface c3sf_result_if;
  logic                         valid;
  logic                         ready;
  logic [c3sf_pkg::PIX_W-1:0]   pixel_out;
  logic [c3sf_pkg::POS_W-1:0]   out_row;
  logic [c3sf_pkg::POS_W-1:0]   out_col;
  logic                         run_last;
  modport source (output valid, pixel_out, out_row, out_col, run_last, input ready);
  modport sink   (input valid, pixel_out, out_row, out_col, run_last, output ready);
endinterface

### hdl/conv3x3_stream_filter_top.sv
// conv3x3_stream_filter_top: streaming 3x3 convolution with border pass-through.
// Depends on c3sf_pkg and the channel interfaces in c3sf_stream_ifs.sv.
// A pixel passes stage 1, the adder stages 2..4 and the result queue before its result is offered.
// Throughput: one pixel per cycle while the result queue has room; the result port
// moves one result per cycle, so a pixel giving two results can hold the input back.
// The line store is one memory with a registered read, read-modify-written once per pixel.
// Reset (synchronous, rst high): registers to defaults, window and position cleared.
module conv3x3_stream_filter_top (
  input  logic                              clk,
  input  logic                              rst,
  c3sf_pixel_if.sink                        pixels,
  c3sf_result_if.source                     results,
  input  logic                              cfg_we,
  input  logic [c3sf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [c3sf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW = c3sf_pkg::PIX_W;
  localparam int SW = c3sf_pkg::SIZE_W;

  // ---------------- configuration ----------------
  logic [SW-1:0]                       image_width;
  logic [SW-1:0]                       image_height;
  logic [c3sf_pkg::KROW_W-1:0]         krow [3];
  logic [c3sf_pkg::SHIFT_W-1:0]        result_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= c3sf_pkg::WIDTH_RESET;
      image_height <= c3sf_pkg::HEIGHT_RESET;
      krow[0]      <= c3sf_pkg::KROW_OUTER_RESET;
      krow[1]      <= c3sf_pkg::KROW_MID_RESET;
      krow[2]      <= c3sf_pkg::KROW_OUTER_RESET;
      result_shift <= c3sf_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        c3sf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[SW-1:0];
        c3sf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[SW-1:0];
        c3sf_pkg::REG_KROW_TOP:     krow[0]      <= cfg_data;
        c3sf_pkg::REG_KROW_MID:     krow[1]      <= cfg_data;
        c3sf_pkg::REG_KROW_BOTTOM:  krow[2]      <= cfg_data;
        c3sf_pkg::REG_RESULT_SHIFT: result_shift <= cfg_data[c3sf_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] w_eff, h_eff;
  assign w_eff = c3sf_pkg::clamp_size(image_width,  SW'(c3sf_pkg::MAX_WIDTH));
  assign h_eff = c3sf_pkg::clamp_size(image_height, SW'(c3sf_pkg::MAX_HEIGHT));

  // ---------------- position, stage 0 ----------------
  logic [c3sf_pkg::ROW_W-1:0] row_count, row_count_next;
  logic [c3sf_pkg::COL_W-1:0] col_count, col_count_next;
  logic [SW-1:0]              cur_r, cur_c, nxt_c, nxt_r;
  c3sf_pkg::meta_t            meta0;
  logic                       accept;

  always_comb begin
    cur_r = pixels.frame_start ? '0 : SW'(row_count);
    cur_c = pixels.frame_start ? '0 : SW'(col_count);
    if (cur_c >= w_eff) begin
      cur_c = '0;
      cur_r = cur_r + SW'(1);
    end
    if (cur_r >= h_eff) cur_r = '0;

    nxt_c = cur_c + SW'(1);
    nxt_r = cur_r;
    if (nxt_c >= w_eff) begin
      nxt_c = '0;
      nxt_r = cur_r + SW'(1);
      if (nxt_r >= h_eff) nxt_r = '0;
    end
    row_count_next = nxt_r[c3sf_pkg::ROW_W-1:0];
    col_count_next = nxt_c[c3sf_pkg::COL_W-1:0];

    meta0.pix      = pixels.pixel_in;
    meta0.row      = cur_r[c3sf_pkg::POS_W-1:0];
    meta0.col      = cur_c[c3sf_pkg::POS_W-1:0];
    meta0.has_int  = (cur_r >= SW'(2)) && (cur_c >= SW'(2));
    meta0.has_bord = (cur_r == '0) || (cur_r == h_eff - SW'(1)) ||
                     (cur_c == '0) || (cur_c == w_eff - SW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // ---------------- line store: {row before previous, previous row} ----------------
  logic [2*PW-1:0]            line_mem [c3sf_pkg::MAX_WIDTH];
  logic [2*PW-1:0]            line_rdata;
  logic [2*PW-1:0]            line_wdata;
  logic [c3sf_pkg::COL_W-1:0] rd_addr;

  assign rd_addr = cur_c[c3sf_pkg::COL_W-1:0];

  // stage 1 registers
  logic                       s1_valid;
  c3sf_pkg::meta_t            s1_meta;
  logic [c3sf_pkg::COL_W-1:0] s1_addr;
  logic                       fwd_hit;
  logic [2*PW-1:0]            fwd_data;

  always_ff @(posedge clk) begin
    if (accept) line_rdata <= line_mem[rd_addr];
    if (s1_valid) line_mem[s1_addr] <= line_wdata;
  end

  // a read issued while the previous pixel writes the same column sees old data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta  <= meta0;
      s1_addr  <= rd_addr;
      fwd_hit  <= s1_valid && (s1_addr == rd_addr);
      fwd_data <= line_wdata;
    end
  end

  // ---------------- stage 1: window shift and products ----------------
  logic [2*PW-1:0] col_word;
  logic [PW-1:0]   window      [9];
  logic [PW-1:0]   window_next [9];
  logic signed [c3sf_pkg::PROD_W-1:0] prod [9];

  always_comb begin
    col_word   = fwd_hit ? fwd_data : line_rdata;
    line_wdata = {col_word[PW-1:0], s1_meta.pix};
    for (int i = 0; i < 3; i++) begin
      window_next[i*3+0] = window[i*3+1];
      window_next[i*3+1] = window[i*3+2];
    end
    window_next[2] = col_word[2*PW-1:PW];
    window_next[5] = col_word[PW-1:0];
    window_next[8] = s1_meta.pix;
    // kernel is applied flipped
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        prod[a*3+b] = c3sf_pkg::PROD_W'($signed({1'b0, window_next[(2-a)*3+(2-b)]})) *
                      c3sf_pkg::PROD_W'(c3sf_pkg::kcoef(krow[a], b));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) window[i] <= '0;
    end else if (s1_valid) begin
      for (int i = 0; i < 9; i++) window[i] <= window_next[i];
    end
  end

  // ---------------- stages 2..4: adder tree and clamp ----------------
  logic                               s2_valid, s3_valid, s4_valid;
  c3sf_pkg::meta_t                    s2_meta, s3_meta, s4_meta;
  logic signed [c3sf_pkg::PROD_W-1:0] s2_prod [9];
  logic signed [c3sf_pkg::RSUM_W-1:0] s3_rsum [3];
  logic signed [c3sf_pkg::SUM_W-1:0]  s4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_meta <= s1_meta;
    for (int i = 0; i < 9; i++) s2_prod[i] <= prod[i];
    s3_meta <= s2_meta;
    for (int a = 0; a < 3; a++) begin
      s3_rsum[a] <= c3sf_pkg::RSUM_W'(s2_prod[a*3]) + c3sf_pkg::RSUM_W'(s2_prod[a*3+1]) +
                    c3sf_pkg::RSUM_W'(s2_prod[a*3+2]);
    end
    s4_meta <= s3_meta;
    s4_sum  <= c3sf_pkg::SUM_W'(s3_rsum[0]) + c3sf_pkg::SUM_W'(s3_rsum[1]) +
               c3sf_pkg::SUM_W'(s3_rsum[2]);
  end

  logic [c3sf_pkg::SUM_W-1:0] shifted;
  logic [PW-1:0]              filt;

  always_comb begin
    shifted = $unsigned(s4_sum) >> result_shift;
    if (s4_sum < 0)                              filt = '0;
    else if (shifted > c3sf_pkg::SUM_W'(c3sf_pkg::PIX_MAX)) filt = c3sf_pkg::PIX_MAX;
    else                                         filt = shifted[PW-1:0];
  end

  // ---------------- result queue ----------------
  c3sf_pkg::entry_t             fifo [c3sf_pkg::FIFO_DEPTH];
  logic [c3sf_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [c3sf_pkg::FIFO_CW-1:0] fifo_count, in_flight, credit_used;
  logic                         push, pop, half;
  c3sf_pkg::entry_t             head;
  logic                         out_last;

  assign push = s4_valid && (s4_meta.has_int || s4_meta.has_bord);
  assign head = fifo[rd_ptr];

  // an interior result goes first, then the border result of the same pixel
  always_comb begin
    results.valid = (fifo_count != '0);
    if (head.meta.has_int && !half) begin
      results.pixel_out = head.filt;
      results.out_row   = head.meta.row - c3sf_pkg::POS_W'(1);
      results.out_col   = head.meta.col - c3sf_pkg::POS_W'(1);
      out_last          = !head.meta.has_bord;
    end else begin
      results.pixel_out = head.meta.pix;
      results.out_row   = head.meta.row;
      results.out_col   = head.meta.col;
      out_last          = 1'b1;
    end
    results.run_last = out_last;
  end

  assign pop = results.valid && results.ready && out_last;

  // every item in the pipe may need one queue slot
  assign in_flight   = c3sf_pkg::FIFO_CW'(s1_valid) + c3sf_pkg::FIFO_CW'(s2_valid) +
                       c3sf_pkg::FIFO_CW'(s3_valid) + c3sf_pkg::FIFO_CW'(s4_valid);
  assign credit_used = fifo_count + in_flight;
  assign pixels.ready = (credit_used < c3sf_pkg::FIFO_CW'(c3sf_pkg::FIFO_DEPTH));
  assign accept       = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].meta <= s4_meta;
      fifo[wr_ptr].filt <= filt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      half       <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + c3sf_pkg::FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + c3sf_pkg::FIFO_AW'(1);
      fifo_count <= fifo_count + c3sf_pkg::FIFO_CW'(push) - c3sf_pkg::FIFO_CW'(pop);
      if (results.valid && results.ready) half <= !out_last;
    end
  end

  // ---------------- checks ----------------
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_used <= c3sf_pkg::FIFO_CW'(c3sf_pkg::FIFO_DEPTH))
    else $error("result queue over-committed");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < c3sf_pkg::FIFO_CW'(c3sf_pkg::FIFO_DEPTH)) || pop)
    else $error("push into full result queue");

  a_head_has_result: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (head.meta.has_int || head.meta.has_bord))
    else $error("queued entry carries no result");

  a_half_needs_pair: assert property (@(posedge clk) disable iff (rst)
    half |-> results.valid && head.meta.has_int && head.meta.has_bord)
    else $error("second phase on entry without two results");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid && (s1_addr == rd_addr)) |=> fwd_hit && s1_valid)
    else $error("missed forward on back-to-back column reuse");

endmodule

### bench/c3sf_result_checker.sv
`timescale 1ns / 100ps
// c3sf_result_checker: mirrors the register writes and pixel transfers, predicts
// the result stream of the 3x3 filter and compares it with the result channel.
// Depends on c3sf_pkg and the channel interfaces in c3sf_stream_ifs.sv.
module c3sf_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  c3sf_pixel_if                           pix_ch,
  c3sf_result_if                          res_ch,
  input  logic                            cfg_we,
  input  logic [c3sf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [c3sf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import c3sf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } out_px_t;

  logic [SIZE_W-1:0]  width_reg, height_reg;
  logic [KROW_W-1:0]  krow [3];
  logic [SHIFT_W-1:0] shift_reg;

  logic [PIX_W-1:0] prev_line  [MAX_WIDTH];
  logic [PIX_W-1:0] older_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];  // [row*3+col], row 0 oldest, col 0 oldest
  int row_pos, col_pos;

  out_px_t due_px [$];

  function automatic int eff_size(input logic [SIZE_W-1:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // kernel is applied flipped: K[a][b] meets the window tap (2-a, 2-b)
  function automatic logic [PIX_W-1:0] weighted_px();
    longint acc;
    logic signed [COEF_BITS-1:0] k;
    int a, b;
    acc = 0;
    for (a = 0; a < 3; a++) begin
      for (b = 0; b < 3; b++) begin
        k = krow[a][SLOT_W*b +: COEF_BITS];
        acc += longint'(k) * longint'({1'b0, win[(2-a)*3 + (2-b)]});
      end
    end
    if (acc < 0) return '0;
    acc = acc >>> shift_reg;
    if (acc > 255) return PIX_MAX;
    return acc[PIX_W-1:0];
  endfunction

  function automatic void step_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int w, h, r, c, i;
    bit interior, border;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    // a size lowered in mid frame can leave the position past the edge
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;

    for (i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2] = older_line[c];
    win[5] = prev_line[c];
    win[8] = px;
    older_line[c] = prev_line[c];
    prev_line[c]  = px;

    interior = (r >= 2) && (c >= 2);
    border   = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
    if (interior)
      due_px.push_back('{pix: weighted_px(), row: POS_W'(r - 1), col: POS_W'(c - 1),
                         last: !border});
    if (border)
      due_px.push_back('{pix: px, row: POS_W'(r), col: POS_W'(c), last: 1'b1});

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void flag_mismatch(input string why, input out_px_t want,
                                        input out_px_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected pix %0d row %0d col %0d last %0b, got pix %0d row %0d col %0d last %0b",
               $time, why, want.pix, want.row, want.col, want.last,
               got.pix, got.row, got.col, got.last);
  endfunction

  always @(posedge clk) begin
    out_px_t got, want;
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      krow[0]    = KROW_OUTER_RESET;
      krow[1]    = KROW_MID_RESET;
      krow[2]    = KROW_OUTER_RESET;
      shift_reg  = SHIFT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        prev_line[i]  = '0;
        older_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      row_pos = 0;
      col_pos = 0;
      due_px.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = cfg_data[SIZE_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_data[SIZE_W-1:0];
          REG_KROW_TOP:     krow[0]    = cfg_data[KROW_W-1:0];
          REG_KROW_MID:     krow[1]    = cfg_data[KROW_W-1:0];
          REG_KROW_BOTTOM:  krow[2]    = cfg_data[KROW_W-1:0];
          REG_RESULT_SHIFT: shift_reg  = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (pix_ch.valid && pix_ch.ready)
        step_pixel(pix_ch.pixel_in, pix_ch.frame_start);
      if (res_ch.valid && res_ch.ready) begin
        got = '{pix: res_ch.pixel_out, row: res_ch.out_row, col: res_ch.out_col,
                last: res_ch.run_last};
        if (due_px.size() == 0) begin
          flag_mismatch("result with none due", '0, got);
        end else begin
          want = due_px.pop_front();
          if (got.pix !== want.pix || got.row !== want.row ||
              got.col !== want.col || got.last !== want.last)
            flag_mismatch("result mismatch", want, got);
        end
      end
    end
    outstanding <= due_px.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for conv3x3_stream_filter_top; prediction and
// comparison sit in c3sf_result_checker. Depends on c3sf_pkg and the interfaces.
module tb;
  import c3sf_pkg::*;

  localparam int RANDOM_PIXELS = 330;
  localparam int DRAIN_QUIET   = 12;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int FRAME_CAP     = 64;

  typedef enum int {K_DEFAULT, K_SMALL, K_FULL, K_EXTREME} kstyle_e;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  bit gaps_on, stalls_on, need_fs;
  int cur_w, cur_h;
  int pixels_sent = 0;
  int stall_left = 0;
  int cycle_count = 0;

  c3sf_pixel_if  pix_ch ();
  c3sf_result_if res_ch ();

  conv3x3_stream_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_ch),
    .results   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  c3sf_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .pix_ch      (pix_ch),
    .res_ch      (res_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure: random bursts with ready low
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 18);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // drop valid and wait until the result stream has gone quiet
  task automatic settle();
    int quiet;
    quiet = 0;
    pix_ch.valid <= 1'b0;
    while (quiet < DRAIN_QUIET) begin
      @(posedge clk);
      quiet = (outstanding == 0) ? quiet + 1 : 0;
    end
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_in    <= px;
    pix_ch.frame_start <= fs;
    do @(posedge clk); while (!pix_ch.ready);
    pixels_sent++;
    if (fs) need_fs = 1'b0;
  endtask

  // all six registers in one burst, only with the block idle
  task automatic write_all(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [KROW_W-1:0] k0, input logic [KROW_W-1:0] k1,
                           input logic [KROW_W-1:0] k2, input logic [SHIFT_W-1:0] sh);
    logic [CFG_DATA_W-1:0] vals [6];
    logic [CFG_IDX_W-1:0]  idxs [6];
    int new_w;
    settle();
    vals = '{CFG_DATA_W'(w), CFG_DATA_W'(h), k0, k1, k2, CFG_DATA_W'(sh)};
    idxs = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_KROW_TOP, REG_KROW_MID,
             REG_KROW_BOTTOM, REG_RESULT_SHIFT};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    new_w = (w < 3) ? 3 : ((w > MAX_WIDTH) ? MAX_WIDTH : int'(w));
    // a wider row would read line store columns never filled: restart the frame
    if (new_w > cur_w) need_fs = 1'b1;
    cur_w = new_w;
    cur_h = (h < 3) ? 3 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : int'(h));
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? PIX_MAX : '0;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [KROW_W-1:0] pick_krow(input kstyle_e style, input bit centre);
    logic [KROW_W-1:0] v;
    logic [SLOT_W-1:0] extreme_slot [4];
    extreme_slot = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
    v = '0;
    case (style)
      K_DEFAULT: v = centre ? KROW_MID_RESET : KROW_OUTER_RESET;
      K_SMALL: begin
        for (int s = 0; s < 3; s++)
          v[SLOT_W*s +: SLOT_W] = SLOT_W'(int'($urandom_range(0, 23)) - 8);
      end
      K_FULL: v = KROW_W'({$urandom(), $urandom()});
      default: begin
        for (int s = 0; s < 3; s++)
          v[SLOT_W*s +: SLOT_W] = extreme_slot[$urandom_range(0, 3)];
      end
    endcase
    return v;
  endfunction

  task automatic random_setup();
    logic [SIZE_W-1:0]  w, h;
    logic [SHIFT_W-1:0] sh;
    kstyle_e style;
    case ($urandom_range(0, 15))
      0:       w = SIZE_W'($urandom_range(0, 2));
      1:       w = SIZE_W'($urandom_range(9, 2047));
      default: w = SIZE_W'($urandom_range(3, 8));
    endcase
    case ($urandom_range(0, 15))
      0:       h = SIZE_W'($urandom_range(0, 2));
      1:       h = SIZE_W'($urandom_range(7, 2047));
      default: h = SIZE_W'($urandom_range(3, 6));
    endcase
    style = kstyle_e'($urandom_range(0, 3));
    case (style)
      K_DEFAULT: sh = ($urandom_range(0, 3) == 0) ? SHIFT_W'($urandom_range(0, 15))
                                                  : SHIFT_RESET;
      K_SMALL:   sh = SHIFT_W'($urandom_range(0, 5));
      default:   sh = SHIFT_W'($urandom_range(0, 15));
    endcase
    write_all(w, h, pick_krow(style, 1'b0), pick_krow(style, 1'b1),
              pick_krow(style, 1'b0), sh);
  endtask

  // mostly whole frames; now and then cut short, restarted mid-way or run on
  // from the previous frame without a frame start
  task automatic send_frame();
    int n, cut, stray;
    bit lead_fs;
    n = cur_w * cur_h;
    if (n > FRAME_CAP) n = FRAME_CAP;
    cut   = n;
    stray = -1;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) cut = $urandom_range(1, n);
      else stray = $urandom_range(1, n - 1);
    end
    lead_fs = need_fs || ($urandom_range(0, 7) != 0);
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(0, 59) == 0) settle();
      push_pixel(random_pixel(), (k == 0 && lead_fs) || k == stray);
    end
  endtask

  initial begin
    int base;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_in    = '0;
    pix_ch.frame_start = 1'b0;
    res_ch.ready       = 1'b1;
    gaps_on            = 1'b1;
    stalls_on          = 1'b1;
    need_fs            = 1'b0;
    cur_w              = int'(WIDTH_RESET);
    cur_h              = int'(HEIGHT_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // smallest frame, most negative kernel: interior sums clamp to zero
    write_all(11'd0, 11'd0, 48'h8000_8000_8000, 48'h8000_8000_8000,
              48'h8000_8000_8000, 4'd0);
    for (int k = 0; k < 9; k++) push_pixel(k[0] ? 8'h00 : 8'hFF, k == 0);
    // largest kernel and shift, clamps high; runs on past the frame end
    write_all(11'd2, 11'd1, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
              48'h7FFF_7FFF_7FFF, 4'd15);
    for (int k = 0; k < 9; k++) push_pixel(8'hFF, 1'b0);

    // frame start in mid row, then the size lowered under the current position
    write_all(11'd4, 11'd4, KROW_OUTER_RESET, KROW_MID_RESET, KROW_OUTER_RESET,
              SHIFT_RESET);
    for (int k = 0; k < 3; k++) push_pixel(random_pixel(), k == 0);
    for (int k = 0; k < 11; k++) push_pixel(random_pixel(), k == 0);
    write_all(11'd3, 11'd3, KROW_OUTER_RESET, KROW_MID_RESET, KROW_OUTER_RESET,
              SHIFT_RESET);
    for (int k = 0; k < 4; k++) push_pixel(random_pixel(), 1'b0);

    // widest row (clamped) for one full row and a little of the next
    write_all(11'd2047, 11'd1024, KROW_OUTER_RESET, KROW_MID_RESET, KROW_OUTER_RESET,
              SHIFT_RESET);
    for (int k = 0; k < MAX_WIDTH + 4; k++) push_pixel(random_pixel(), k == 0);

    base = pixels_sent;
    while (pixels_sent - base < RANDOM_PIXELS) begin
      if (pixels_sent - base >= RANDOM_PIXELS - 50) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = ($urandom_range(0, 9) < 7);
        stalls_on = ($urandom_range(0, 9) < 7);
      end
      if ($urandom_range(0, 2) == 0) random_setup();
      send_frame();
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
